### rtl/core/lcs_pkg.sv
// Shared constants, command codes and interface structs for the LCS block.
// Used by lcs_engine and lcs_length_and_traceback; depends on nothing else.
`default_nettype none

package lcs_pkg;

   localparam int SYM_W       = 8;
   localparam int LEN_W       = 6;
   localparam int CMD_W       = 2;
   localparam int MAX_LEN_DEF = 32;

   localparam logic [CMD_W-1:0] CMD_LOAD_ROW = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_COL = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPUTE  = 2'd2;

   localparam logic KIND_MATCH  = 1'b0;
   localparam logic KIND_LENGTH = 1'b1;

   typedef struct packed {
      logic             wr_row;
      logic             wr_col;
      logic [LEN_W-1:0] idx;
      logic [SYM_W-1:0] sym;
   } lcs_load_type;

   typedef struct packed {
      logic             go;
      logic [LEN_W-1:0] m;
      logic [LEN_W-1:0] n;
   } lcs_start_type;

   typedef struct packed {
      logic             kind;
      logic [SYM_W-1:0] match_symbol;
      logic [LEN_W-1:0] lcs_length;
      logic             last;
   } lcs_result_type;

endpackage

`default_nettype wire

### rtl/core/lcs_engine.sv
// Table fill and traceback sequencer for the LCS block, with the symbol and
// length-table memories. Depends on lcs_pkg.
`default_nettype none

module lcs_engine #(
   parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lcs_pkg::lcs_load_type  load,
   input  lcs_pkg::lcs_start_type start,
   output logic                  busy,
   output logic                  res_valid,
   output lcs_pkg::lcs_result_type res,
   input  logic                  res_ready
);
   import lcs_pkg::*;

   localparam int IW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int AW    = 2 * IW;
   localparam int SDEPTH = 1 << IW;
   localparam int TDEPTH = 1 << AW;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_F_RD,
      ST_F_WR,
      ST_T_RD,
      ST_T_UP,
      ST_T_LF,
      ST_T_EMIT,
      ST_EMIT_LEN
   } state_type;

   state_type        state_ff, state_in;
   logic [LEN_W-1:0] i_ff, i_in, j_ff, j_in, m_ff, m_in, n_ff, n_in;
   logic [LEN_W-1:0] left_ff, left_in, diag_ff, diag_in, up_ff, up_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             match_ff, match_in;
   logic [SYM_W-1:0] sym_ff, sym_in;

   logic [SYM_W-1:0] row_mem_ff [SDEPTH];
   logic [SYM_W-1:0] col_mem_ff [SDEPTH];
   logic [LEN_W-1:0] tbl_mem_ff [TDEPTH];
   logic [SYM_W-1:0] row_q_ff, col_q_ff;
   logic [LEN_W-1:0] tbl_q_ff;

   logic [IW-1:0]    row_rd_addr, col_rd_addr;
   logic [AW-1:0]    tbl_rd_addr, tbl_wr_addr;
   logic             tbl_we;
   logic [LEN_W-1:0] tbl_wd;

   logic [LEN_W-1:0] i_m1, i_m2, j_m1, j_m2;
   logic [LEN_W-1:0] up_val, left_val, diag_val, cell_val;
   logic             sym_eq;

   assign i_m1 = i_ff - LEN_W'(1);
   assign i_m2 = i_ff - LEN_W'(2);
   assign j_m1 = j_ff - LEN_W'(1);
   assign j_m2 = j_ff - LEN_W'(2);

   // implicit zero row and column
   assign up_val   = (i_ff == LEN_W'(1)) ? '0 : tbl_q_ff;
   assign left_val = (j_ff == LEN_W'(1)) ? '0 : left_ff;
   assign diag_val = (j_ff == LEN_W'(1)) ? '0 : diag_ff;
   assign sym_eq   = (row_q_ff == col_q_ff);
   assign cell_val = sym_eq ? diag_val + LEN_W'(1)
                            : ((up_val >= left_val) ? up_val : left_val);

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      m_in        = m_ff;
      n_in        = n_ff;
      left_in     = left_ff;
      diag_in     = diag_ff;
      up_in       = up_ff;
      len_in      = len_ff;
      match_in    = match_ff;
      sym_in      = sym_ff;
      row_rd_addr = i_m1[IW-1:0];
      col_rd_addr = j_m1[IW-1:0];
      tbl_rd_addr = {i_m2[IW-1:0], j_m1[IW-1:0]};
      tbl_wr_addr = {i_m1[IW-1:0], j_m1[IW-1:0]};
      tbl_we      = 1'b0;
      tbl_wd      = cell_val;
      res_valid   = 1'b0;
      res         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start.go) begin
               m_in = start.m;
               n_in = start.n;
               i_in = LEN_W'(1);
               j_in = LEN_W'(1);
               if (start.m == '0 || start.n == '0) begin
                  len_in   = '0;
                  state_in = ST_EMIT_LEN;
               end else begin
                  state_in = ST_F_RD;
               end
            end
         end
         ST_F_RD: begin
            state_in = ST_F_WR;
         end
         ST_F_WR: begin
            tbl_we   = 1'b1;
            left_in  = cell_val;
            diag_in  = up_val;
            len_in   = cell_val;
            state_in = ST_F_RD;
            if (j_ff == n_ff) begin
               j_in = LEN_W'(1);
               if (i_ff == m_ff) begin
                  i_in     = m_ff;
                  j_in     = n_ff;
                  state_in = ST_T_RD;
               end else begin
                  i_in = i_ff + LEN_W'(1);
               end
            end else begin
               j_in = j_ff + LEN_W'(1);
            end
         end
         ST_T_RD: begin
            if (i_ff == '0 || j_ff == '0) begin
               state_in = ST_EMIT_LEN;
            end else begin
               state_in = ST_T_UP;
            end
         end
         ST_T_UP: begin
            // read the left neighbor next, hold the up value
            tbl_rd_addr = {i_m1[IW-1:0], j_m2[IW-1:0]};
            up_in       = up_val;
            match_in    = sym_eq;
            sym_in      = row_q_ff;
            state_in    = ST_T_LF;
         end
         ST_T_LF: begin
            state_in = ST_T_RD;
            if (match_ff) begin
               state_in = ST_T_EMIT;
            end else if (up_ff >= ((j_ff == LEN_W'(1)) ? '0 : tbl_q_ff)) begin
               i_in = i_m1;
            end else begin
               j_in = j_m1;
            end
         end
         ST_T_EMIT: begin
            res_valid        = 1'b1;
            res.kind         = KIND_MATCH;
            res.match_symbol = sym_ff;
            if (res_ready) begin
               i_in     = i_m1;
               j_in     = j_m1;
               state_in = ST_T_RD;
            end
         end
         ST_EMIT_LEN: begin
            res_valid      = 1'b1;
            res.kind       = KIND_LENGTH;
            res.lcs_length = len_ff;
            res.last       = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff     <= i_in;
      j_ff     <= j_in;
      m_ff     <= m_in;
      n_ff     <= n_in;
      left_ff  <= left_in;
      diag_ff  <= diag_in;
      up_ff    <= up_in;
      len_ff   <= len_in;
      match_ff <= match_in;
      sym_ff   <= sym_in;
   end

   always_ff @(posedge clock) begin
      if (load.wr_row) begin
         row_mem_ff[load.idx[IW-1:0]] <= load.sym;
      end
      row_q_ff <= row_mem_ff[row_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (load.wr_col) begin
         col_mem_ff[load.idx[IW-1:0]] <= load.sym;
      end
      col_q_ff <= col_mem_ff[col_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem_ff[tbl_wr_addr] <= tbl_wd;
      end
      tbl_q_ff <= tbl_mem_ff[tbl_rd_addr];
   end

endmodule

`default_nettype wire

### rtl/core/lcs_length_and_traceback.sv
// Top level of the LCS block: request decode, string counts, result register.
// Depends on lcs_pkg and lcs_engine.
`default_nettype none

// Longest common subsequence of two byte strings. Load words (cmd 0 row,
// cmd 1 column) are taken one per cycle while req_stall is low and append
// a symbol; a load into a string already MAX_LEN long is dropped. A compute
// word clears both counts and fills the m x n length table (the up neighbor
// comes from a registered read of the table memory in the read state, the
// cell is computed and written in the write state), then walks back from the
// last cell, reading the up and then the left neighbor at each step. Matched
// symbols come out last to first with kind 0, then one word with kind 1, the
// length and last set. req_stall stays high from the compute word until the
// length word is handed to the output register. Command 3 is ignored.
module lcs_length_and_traceback #(
   parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [lcs_pkg::CMD_W-1:0] req_cmd,
   input  logic [lcs_pkg::SYM_W-1:0] req_symbol,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_kind,
   output logic [lcs_pkg::SYM_W-1:0] rsp_match_symbol,
   output logic [lcs_pkg::LEN_W-1:0] rsp_lcs_length,
   output logic                      rsp_last
);
   import lcs_pkg::*;

   logic             req_take;
   logic [LEN_W-1:0] row_count_ff, row_count_in, col_count_ff, col_count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   lcs_result_type   rsp_ff, rsp_in;

   lcs_load_type     load;
   lcs_start_type    start;
   logic             eng_busy, eng_res_valid, eng_res_ready;
   lcs_result_type   eng_res;

   assign req_stall = eng_busy;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      load         = '0;
      load.sym     = req_symbol;
      start        = '0;
      start.m      = row_count_ff;
      start.n      = col_count_ff;
      if (req_take) begin
         unique case (req_cmd)
            CMD_LOAD_ROW: begin
               if (row_count_ff < LEN_W'(MAX_LEN)) begin
                  load.wr_row  = 1'b1;
                  load.idx     = row_count_ff;
                  row_count_in = row_count_ff + LEN_W'(1);
               end
            end
            CMD_LOAD_COL: begin
               if (col_count_ff < LEN_W'(MAX_LEN)) begin
                  load.wr_col  = 1'b1;
                  load.idx     = col_count_ff;
                  col_count_in = col_count_ff + LEN_W'(1);
               end
            end
            CMD_COMPUTE: begin
               start.go     = 1'b1;
               row_count_in = '0;
               col_count_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   lcs_engine #(
      .MAX_LEN(MAX_LEN)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .start    (start),
      .busy     (eng_busy),
      .res_valid(eng_res_valid),
      .res      (eng_res),
      .res_ready(eng_res_ready)
   );

   // output register: refill when empty or being drained
   assign eng_res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (eng_res_ready) begin
         rsp_valid_in = eng_res_valid;
         if (eng_res_valid) begin
            rsp_in = eng_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= '0;
         col_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_ff.kind;
   assign rsp_match_symbol = rsp_ff.match_symbol;
   assign rsp_lcs_length   = rsp_ff.lcs_length;
   assign rsp_last         = rsp_ff.last;

   a_len_word_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == rsp_last))
      else $error("length word and last flag disagree");

   a_match_word_no_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_MATCH |-> rsp_lcs_length == '0)
      else $error("match word carries a length");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      row_count_ff <= LEN_W'(MAX_LEN) && col_count_ff <= LEN_W'(MAX_LEN))
      else $error("string count beyond capacity");

   a_compute_stalls: assert property (@(posedge clock) disable iff (reset)
      req_take && req_cmd == CMD_COMPUTE |=> req_stall && row_count_ff == '0)
      else $error("compute word did not start the engine");

endmodule

`default_nettype wire
